/* sv/byte_ring_buffer_fifo_defines.svh */
// ----------------------------------------------------------------------------
// Byte ring buffer FIFO assertion macros
// Concurrent assertion wrappers clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_BUFFER_FIFO_DEFINES_SVH
`define BYTE_RING_BUFFER_FIFO_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define BRB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define BRB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BRB_ASSERT_IMP(lbl, ante, cons, msg)
`define BRB_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

/* sv/brb_pkg.sv */
// ----------------------------------------------------------------------------
// Byte ring buffer package
// Sizes, request kinds, queue entry type and index helpers.
// ----------------------------------------------------------------------------
package brb_pkg;

  localparam int unsigned DEPTH     = 1024;
  localparam int unsigned MAX_BURST = 64;
  localparam int unsigned AW        = $clog2(DEPTH);
  localparam int unsigned CW        = $clog2(DEPTH + 1);      // counts, capacity, fill level
  localparam int unsigned DW        = 8;
  localparam int unsigned LW        = $clog2(MAX_BURST + 1);  // burst length
  localparam int unsigned TW        = 2;   // request type code

  localparam logic [TW-1:0] REQ_WRITE = 2'd0;
  localparam logic [TW-1:0] REQ_READ  = 2'd1;
  localparam logic [TW-1:0] REQ_PEEK  = 2'd2;
  localparam logic [TW-1:0] REQ_CLEAR = 2'd3;

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_READ,
    KIND_PEEK,
    KIND_CLEAR
  } kind_e;

  typedef struct packed {
    kind_e          kind;
    logic [DW-1:0]  data;
    logic [LW-1:0]  len;   // already limited to MAX_BURST
  } req_t;

  typedef struct packed {
    logic valid;
    req_t req;
  } qhead_t;

  // Limit a written capacity to 1..DEPTH.
  function automatic logic [CW-1:0] eff_cap(logic [CW-1:0] v);
    logic [CW-1:0] c;
    c = v;
    if (c == '0) c = CW'(1);
    if (c > CW'(DEPTH)) c = CW'(DEPTH);
    return c;
  endfunction

  // (base + inc) modulo cap, valid while base < cap and inc <= cap.
  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [CW-1:0] inc,
                                              logic [CW-1:0] cap);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(inc);
    if (s >= (CW+1)'(cap)) s = s - (CW+1)'(cap);
    return s[AW-1:0];
  endfunction

endpackage

/* sv/brb_req_if.sv */
// ----------------------------------------------------------------------------
// Byte ring buffer request channel
// Valid/ready channel carrying one request.
// ----------------------------------------------------------------------------
interface brb_req_if;
  logic                     valid;
  logic                     ready;
  logic [brb_pkg::TW-1:0]   req_type;
  logic [brb_pkg::DW-1:0]   wr_data;
  logic [brb_pkg::LW-1:0]   burst_len;

  modport source (output valid, req_type, wr_data, burst_len, input ready);
  modport sink   (input valid, req_type, wr_data, burst_len, output ready);
endinterface

/* sv/brb_rsp_if.sv */
// ----------------------------------------------------------------------------
// Byte ring buffer result channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface brb_rsp_if;
  logic                     valid;
  logic                     ready;
  logic [brb_pkg::DW-1:0]   rd_data;
  logic                     data_valid;
  logic                     last;
  logic [brb_pkg::CW-1:0]   op_count;
  logic [brb_pkg::CW-1:0]   fill_level;

  modport source (output valid, rd_data, data_valid, last, op_count, fill_level,
                  input ready);
  modport sink   (input valid, rd_data, data_valid, last, op_count, fill_level,
                  output ready);
endinterface

/* sv/brb_front.sv */
// ----------------------------------------------------------------------------
// Byte ring buffer front end
// Decodes requests, limits burst length and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module brb_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  brb_req_if.sink          req_i,
  input  logic             pop_i,
  output brb_pkg::qhead_t  qh_o
);

  brb_pkg::req_t  entry_q [2];
  brb_pkg::req_t  dec;
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           push, pop;

  // Classify the incoming request.
  always_comb begin
    dec = '0;
    case (req_i.req_type)
      brb_pkg::REQ_WRITE: dec.kind = brb_pkg::KIND_WRITE;
      brb_pkg::REQ_READ:  dec.kind = brb_pkg::KIND_READ;
      brb_pkg::REQ_PEEK:  dec.kind = brb_pkg::KIND_PEEK;
      brb_pkg::REQ_CLEAR: dec.kind = brb_pkg::KIND_CLEAR;
      default:            dec.kind = brb_pkg::KIND_WRITE;
    endcase
    dec.data = req_i.wr_data;
    dec.len  = (req_i.burst_len > brb_pkg::LW'(brb_pkg::MAX_BURST)) ?
               brb_pkg::LW'(brb_pkg::MAX_BURST) : req_i.burst_len;
  end

  assign req_i.ready = (cnt_q != 2'd2);
  assign push        = req_i.valid && req_i.ready;
  assign pop         = pop_i && (cnt_q != 2'd0);

  assign qh_o.valid  = (cnt_q != 2'd0);
  assign qh_o.req    = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

/* sv/brb_back.sv */
// ----------------------------------------------------------------------------
// Byte ring buffer back end
// Owns the byte store, head and fill; executes requests and emits results.
// ----------------------------------------------------------------------------
module brb_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [brb_pkg::CW-1:0]  cfg_data_i,
  input  brb_pkg::qhead_t         qh_i,
  output logic                    pop_o,
  brb_rsp_if.source               rsp_o
);

  typedef enum logic {ST_IDLE, ST_BURST} state_e;

  localparam int unsigned AW = brb_pkg::AW;
  localparam int unsigned CW = brb_pkg::CW;
  localparam int unsigned DW = brb_pkg::DW;
  localparam int unsigned LW = brb_pkg::LW;

  logic [DW-1:0] mem [brb_pkg::DEPTH];
  logic [DW-1:0] rdata_q;

  state_e        state_q, state_d;
  logic [AW-1:0] head_q, head_d, ptr_q, ptr_d;
  logic [CW-1:0] fill_q, fill_d, cap_q;
  logic [LW-1:0] rem_q, rem_d, bcnt_q, bcnt_d;
  logic [CW-1:0] bfill_q, bfill_d;

  // Stage between store read and output register.
  logic          p_valid_q, p_dv_q, p_last_q;
  logic [CW-1:0] p_cnt_q, p_fill_q;
  logic          p_load, p_dv_d, p_last_d;
  logic [CW-1:0] p_cnt_d, p_fill_d;

  // Output register.
  logic          out_valid_q, out_dv_q, out_last_q;
  logic [DW-1:0] out_data_q;
  logic [CW-1:0] out_cnt_q, out_fill_q;

  logic          out_free, issue_ok;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [LW-1:0] n;
  logic [CW-1:0] fill_after;
  logic          cfg_take;

  assign out_free = !out_valid_q || rsp_o.ready;
  assign issue_ok = !p_valid_q || out_free;
  assign pop_o    = (state_q == ST_IDLE) && qh_i.valid && issue_ok;

  // Capacity changes only take effect on an empty buffer.
  assign cfg_take = cfg_we_i && (fill_q == '0);

  assign n = (CW'(qh_i.req.len) < fill_q) ? qh_i.req.len : fill_q[LW-1:0];
  assign fill_after = (qh_i.req.kind == brb_pkg::KIND_READ) ? (fill_q - CW'(n)) : fill_q;

  assign mem_waddr = brb_pkg::wrap_add(head_q, fill_q, cap_q);

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    fill_d    = fill_q;
    ptr_d     = ptr_q;
    rem_d     = rem_q;
    bcnt_d    = bcnt_q;
    bfill_d   = bfill_q;
    p_load    = 1'b0;
    p_dv_d    = 1'b0;
    p_last_d  = 1'b1;
    p_cnt_d   = '0;
    p_fill_d  = fill_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = head_q;
    case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          p_load = 1'b1;
          case (qh_i.req.kind)
            brb_pkg::KIND_WRITE: begin
              if (fill_q < cap_q) begin
                mem_we  = 1'b1;
                fill_d  = fill_q + CW'(1);
                p_cnt_d = CW'(1);
              end
              p_fill_d = fill_d;
            end
            brb_pkg::KIND_CLEAR: begin
              p_cnt_d  = fill_q;
              p_fill_d = '0;
              fill_d   = '0;
              head_d   = '0;
            end
            brb_pkg::KIND_READ, brb_pkg::KIND_PEEK: begin
              p_cnt_d  = CW'(n);
              p_fill_d = fill_after;
              if (n != '0) begin
                mem_re   = 1'b1;
                p_dv_d   = 1'b1;
                p_last_d = (n == LW'(1));
                ptr_d    = brb_pkg::wrap_add(head_q, CW'(1), cap_q);
                rem_d    = n - LW'(1);
                bcnt_d   = n;
                bfill_d  = fill_after;
                if (n != LW'(1)) state_d = ST_BURST;
                // Consume up front; later reads follow the burst pointer.
                if (qh_i.req.kind == brb_pkg::KIND_READ) begin
                  fill_d = fill_after;
                  head_d = (fill_after == '0) ? '0 :
                           brb_pkg::wrap_add(head_q, CW'(n), cap_q);
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_BURST: begin
        if (issue_ok) begin
          p_load    = 1'b1;
          mem_re    = 1'b1;
          mem_raddr = ptr_q;
          p_dv_d    = 1'b1;
          p_last_d  = (rem_q == LW'(1));
          p_cnt_d   = CW'(bcnt_q);
          p_fill_d  = bfill_q;
          ptr_d     = brb_pkg::wrap_add(ptr_q, CW'(1), cap_q);
          rem_d     = rem_q - LW'(1);
          if (rem_q == LW'(1)) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    // A new capacity restarts the ring at slot zero.
    if (cfg_take) head_d = '0;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= qh_i.req.data;
    if (mem_re) rdata_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      fill_q      <= '0;
      cap_q       <= CW'(brb_pkg::DEPTH);
      ptr_q       <= '0;
      rem_q       <= '0;
      bcnt_q      <= '0;
      bfill_q     <= '0;
      p_valid_q   <= 1'b0;
      p_dv_q      <= 1'b0;
      p_last_q    <= 1'b0;
      p_cnt_q     <= '0;
      p_fill_q    <= '0;
      out_valid_q <= 1'b0;
      out_dv_q    <= 1'b0;
      out_last_q  <= 1'b0;
      out_data_q  <= '0;
      out_cnt_q   <= '0;
      out_fill_q  <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      fill_q  <= fill_d;
      ptr_q   <= ptr_d;
      rem_q   <= rem_d;
      bcnt_q  <= bcnt_d;
      bfill_q <= bfill_d;
      if (cfg_take) begin
        cap_q <= brb_pkg::eff_cap(cfg_data_i);
      end
      if (out_free) begin
        out_valid_q <= p_valid_q;
        if (p_valid_q) begin
          out_dv_q   <= p_dv_q;
          out_last_q <= p_last_q;
          out_data_q <= p_dv_q ? rdata_q : '0;
          out_cnt_q  <= p_cnt_q;
          out_fill_q <= p_fill_q;
        end
      end
      if (p_load) begin
        p_valid_q <= 1'b1;
        p_dv_q    <= p_dv_d;
        p_last_q  <= p_last_d;
        p_cnt_q   <= p_cnt_d;
        p_fill_q  <= p_fill_d;
      end else if (out_free) begin
        p_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.rd_data    = out_data_q;
  assign rsp_o.data_valid = out_dv_q;
  assign rsp_o.last       = out_last_q;
  assign rsp_o.op_count   = out_cnt_q;
  assign rsp_o.fill_level = out_fill_q;

endmodule

/* sv/byte_ring_buffer_fifo.sv */
// ----------------------------------------------------------------------------
// Byte ring buffer FIFO
// Circular byte FIFO with write, read burst, peek burst and clear requests.
// ----------------------------------------------------------------------------
// Usage:
//  - req_i takes one request per valid/ready handshake: write one byte, read
//    or peek up to 64 bytes, or clear. Requests land in a two-entry queue, so
//    req_i.ready drops only when both entries wait.
//  - rsp_o returns results: one per write, clear or empty burst, and one per
//    byte for a burst that returns data, with last marking the final one.
//  - cfg_we_i/cfg_data_i set the capacity in use (1..1024, out-of-range values
//    are limited); a write while bytes are held is ignored.
//  - The first result of a request passes the request queue, the store read
//    stage and the output register before it is presented. Throughput: one
//    result per cycle while the receiver takes results; a burst holds the
//    execution unit until its last byte is issued, since the byte store has a
//    single read port.
//  - Reset empties the buffer and restores capacity 1024; the byte store is
//    not cleared, since only bytes written since the last fill are read.
//  - When the receiver stalls, the output register and the store-read stage
//    hold, execution pauses, and the queue fills until req_i.ready drops.
// ----------------------------------------------------------------------------
`include "byte_ring_buffer_fifo_defines.svh"

module byte_ring_buffer_fifo (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [brb_pkg::CW-1:0]  cfg_data_i,
  brb_req_if.sink                 req_i,
  brb_rsp_if.source               rsp_o
);

  brb_pkg::qhead_t qh;
  logic            pop;

  // Front: accept and classify requests, buffer them.
  brb_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .pop_i  (pop),
    .qh_o   (qh)
  );

  // Back: execute against the byte store and drive the results.
  brb_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .qh_i       (qh),
    .pop_o      (pop),
    .rsp_o      (rsp_o)
  );

  // A queued request stays until the back end takes it.
  `BRB_ASSERT_NXT(a_queue_hold, qh.valid && !pop, qh.valid, "queued request lost")
  // A full queue always presents a request.
  `BRB_ASSERT_IMP(a_full_has_head, !req_i.ready, qh.valid, "full queue shows no request")
  // Results without a byte carry zero data.
  `BRB_ASSERT_IMP(a_zero_data, rsp_o.valid && !rsp_o.data_valid, rsp_o.rd_data == '0,
                  "non-data result carries data")
  // A byte result belongs to a burst of 1..MAX_BURST bytes.
  `BRB_ASSERT_IMP(a_burst_count, rsp_o.valid && rsp_o.data_valid,
                  (rsp_o.op_count != '0) && (rsp_o.op_count <= brb_pkg::CW'(brb_pkg::MAX_BURST)),
                  "burst count out of range")
  // Fill level never exceeds the store depth.
  `BRB_ASSERT_IMP(a_fill_range, rsp_o.valid, rsp_o.fill_level <= brb_pkg::CW'(brb_pkg::DEPTH),
                  "fill level out of range")

endmodule
